// File: src/cli_pkg.sv
// shared widths, op codes, stage bundles and helpers for the cubic lagrange interpolator
package cli_pkg;

  localparam int IN_W    = 32;
  localparam int DIFF_W  = IN_W + 1;
  localparam int PAIR_W  = 2 * DIFF_W;
  localparam int NUM_W   = 3 * DIFF_W;
  localparam int DEN_W   = 3 * DIFF_W;
  localparam int PROD_W  = IN_W + NUM_W;
  localparam int TERM_W  = PROD_W + 1;
  localparam int SUM_W   = TERM_W + 2;
  localparam int LANE_LAT = 6;
  localparam int DIV_LAT  = PROD_W + 1;
  localparam int MID_LAT  = LANE_LAT + DIV_LAT;

  localparam logic [1:0] OP_VALUE = 2'd0;
  localparam logic [1:0] OP_SLOPE = 2'd1;
  localparam logic [1:0] OP_CURVE = 2'd2;
  // unused code, answers zero
  localparam logic [1:0] OP_SPARE = 2'd3;

  typedef struct packed {
    logic [1:0]               op;
    logic signed [IN_W-1:0]   g;
    logic signed [DIFF_W-1:0] a;
    logic signed [DIFF_W-1:0] b;
    logic signed [DIFF_W-1:0] c;
    logic signed [DIFF_W-1:0] p;
    logic signed [DIFF_W-1:0] q;
    logic signed [DIFF_W-1:0] r;
  } lane_in_t;

  typedef struct packed {
    logic [PROD_W-1:0] num_mag;
    logic [DEN_W-1:0]  den_mag;
    logic              neg;
  } div_in_t;

  // index of the m-th node other than node i
  function automatic logic [1:0] other_node(input logic [1:0] i, input logic [1:0] m);
    other_node = (m < i) ? m : m + 2'd1;
  endfunction

endpackage

// File: src/cli_req_if.sv
// input channel: op, abscissa, node positions and node values
interface cli_req_if;
  logic              valid;
  logic              ready;
  logic [1:0]        op;
  logic signed [31:0] point;
  logic signed [31:0] node_0;
  logic signed [31:0] node_1;
  logic signed [31:0] node_2;
  logic signed [31:0] node_3;
  logic signed [31:0] sample_0;
  logic signed [31:0] sample_1;
  logic signed [31:0] sample_2;
  logic signed [31:0] sample_3;

  modport source (output valid, op, point, node_0, node_1, node_2, node_3,
                  sample_0, sample_1, sample_2, sample_3, input ready);
  modport sink (input valid, op, point, node_0, node_1, node_2, node_3,
                sample_0, sample_1, sample_2, sample_3, output ready);
endinterface

// File: src/cli_rsp_if.sv
// result channel: saturated answer with overflow and coincident node flags
interface cli_rsp_if;
  logic              valid;
  logic              ready;
  logic signed [31:0] answer;
  logic              saturated;
  logic              degenerate;

  modport source (output valid, answer, saturated, degenerate, input ready);
  modport sink (input valid, answer, saturated, degenerate, output ready);
endinterface

// File: src/cli_lane.sv
// per-node term lane: difference products, numerator select, sample product, magnitudes
module cli_lane #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               en,
  input  cli_pkg::lane_in_t  li,
  output cli_pkg::div_in_t   lo
);
  localparam int DW = cli_pkg::DIFF_W;
  localparam int PW2 = cli_pkg::PAIR_W;
  localparam int NW = cli_pkg::NUM_W;
  localparam int PW = cli_pkg::PROD_W;
  localparam int IW = cli_pkg::IN_W;

  // stage 1
  logic signed [PW2-1:0] ab, ac, bc, pq;
  logic signed [DW-1:0]  c1, r1;
  logic signed [DW+1:0]  s1;
  logic signed [IW-1:0]  g1;
  logic [1:0]            op1;
  // stage 2
  logic signed [PW2-1:0] abh_c, pqh_r;
  logic signed [PW2:0]   abl_c, pql_r;
  logic signed [PW2+1:0] sum2;
  logic signed [DW+1:0]  s2;
  logic signed [IW-1:0]  g2;
  logic [1:0]            op2;
  // stage 3
  logic signed [NW-1:0]  abc_c, den_c, num_next;
  logic signed [NW-1:0]  num3, den3;
  logic signed [IW-1:0]  g3;
  // stage 4
  logic signed [DW+IW-1:0] pt4;
  logic signed [DW+IW:0]   pm4, pl4;
  logic signed [NW-1:0]    den4;
  // stage 5
  logic signed [PW-1:0]  prod5;
  logic signed [NW-1:0]  den5;

  always_ff @(posedge clk) begin
    if (en) begin
      ab  <= li.a * li.b;
      ac  <= li.a * li.c;
      bc  <= li.b * li.c;
      pq  <= li.p * li.q;
      c1  <= li.c;
      r1  <= li.r;
      s1  <= li.a + li.b + li.c;
      g1  <= li.g;
      op1 <= li.op;
    end
  end

  // wide factor split into a signed upper half and an unsigned lower half
  always_ff @(posedge clk) begin
    if (en) begin
      abh_c <= $signed(ab[PW2-1:DW]) * c1;
      abl_c <= $signed({1'b0, ab[DW-1:0]}) * c1;
      pqh_r <= $signed(pq[PW2-1:DW]) * r1;
      pql_r <= $signed({1'b0, pq[DW-1:0]}) * r1;
      sum2  <= ab + ac + bc;
      s2    <= s1;
      g2    <= g1;
      op2   <= op1;
    end
  end

  always_comb begin
    abc_c = (NW'(abh_c) <<< DW) + NW'(abl_c);
    den_c = (NW'(pqh_r) <<< DW) + NW'(pql_r);
    case (op2)
      cli_pkg::OP_VALUE: num_next = abc_c;
      cli_pkg::OP_SLOPE: num_next = NW'(sum2) <<< FRAC_BITS;
      cli_pkg::OP_CURVE: num_next = NW'(s2) <<< (1 + 2 * FRAC_BITS);
      default:           num_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num3 <= num_next;
      den3 <= den_c;
      g3   <= g2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pt4  <= $signed(num3[NW-1:2*DW]) * g3;
      pm4  <= $signed({1'b0, num3[2*DW-1:DW]}) * g3;
      pl4  <= $signed({1'b0, num3[DW-1:0]}) * g3;
      den4 <= den3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod5 <= (PW'(pt4) <<< (2 * DW)) + (PW'(pm4) <<< DW) + PW'(pl4);
      den5  <= den4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lo.num_mag <= prod5[PW-1] ? -prod5 : prod5;
      lo.den_mag <= den5[NW-1] ? -den5 : den5;
      lo.neg     <= prod5[PW-1] ^ den5[NW-1];
    end
  end

endmodule

// File: src/cli_div.sv
// pipelined restoring divider, one quotient bit per stage, signed result
module cli_div (
  input  logic                               clk,
  input  logic                               en,
  input  cli_pkg::div_in_t                   di,
  output logic signed [cli_pkg::TERM_W-1:0]  term
);
  localparam int QW = cli_pkg::PROD_W;
  localparam int DW = cli_pkg::DEN_W;

  logic [DW-1:0] rem_s [1:QW];
  logic [QW-1:0] num_s [1:QW];
  logic [DW-1:0] den_s [1:QW];
  logic          neg_s [1:QW];
  logic [cli_pkg::TERM_W-1:0] qx;

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [DW-1:0] cur_rem, cur_den;
    logic [QW-1:0] cur_num;
    logic          cur_neg;
    logic [DW:0]   trial, diff;
    logic          fit;

    if (k == 0) begin : g_first
      assign cur_rem = '0;
      assign cur_num = di.num_mag;
      assign cur_den = di.den_mag;
      assign cur_neg = di.neg;
    end else begin : g_next
      assign cur_rem = rem_s[k];
      assign cur_num = num_s[k];
      assign cur_den = den_s[k];
      assign cur_neg = neg_s[k];
    end

    always_comb begin
      trial = {cur_rem, cur_num[QW-1]};
      diff  = trial - {1'b0, cur_den};
      fit   = trial >= {1'b0, cur_den};
    end

    // dividend bits leave at the top, quotient bits enter at the bottom
    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[k+1] <= fit ? diff[DW-1:0] : trial[DW-1:0];
        num_s[k+1] <= {cur_num[QW-2:0], fit};
        den_s[k+1] <= cur_den;
        neg_s[k+1] <= cur_neg;
      end
    end
  end

  assign qx = {1'b0, num_s[QW]};

  always_ff @(posedge clk) begin
    if (en) begin
      term <= neg_s[QW] ? -qx : qx;
    end
  end

endmodule

// File: src/cubic_lagrange_interpolator.sv
// top level: node differences, four term lanes and dividers, sum, saturation, output skid
// an accepted input beat passes the input register, lanes, dividers, pair sums, final and output registers to rsp
// throughput: one beat per cycle while the skid slot is empty; depth is set by the four
//   131-stage dividers that retire one quotient bit per stage
// the whole pipeline advances together and stalls only while the skid slot is full
// reset (synchronous, rst high) clears valid bits, output and skid; no payload is cleared
module cubic_lagrange_interpolator #(
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  cli_req_if.sink      req,
  cli_rsp_if.source    rsp
);
  localparam int IW = cli_pkg::IN_W;
  localparam int DW = cli_pkg::DIFF_W;
  localparam int TW = cli_pkg::TERM_W;
  localparam int SW = cli_pkg::SUM_W;
  localparam int ML = cli_pkg::MID_LAT;

  typedef struct packed {
    logic       vld;
    logic [1:0] op;
    logic       degen;
  } side_t;

  typedef struct packed {
    logic [IW-1:0] answer;
    logic          saturated;
    logic          degenerate;
  } res_t;

  logic en;
  logic signed [IW-1:0] nodes [4];
  logic signed [IW-1:0] samples [4];
  cli_pkg::lane_in_t lane_next [4];
  cli_pkg::lane_in_t lane_q [4];
  cli_pkg::div_in_t  div_in [4];
  logic signed [TW-1:0] term [4];
  logic degen_next;
  side_t side0, side_a;
  side_t side_d [ML];
  logic signed [TW:0]   p01, p23;
  logic signed [SW-1:0] sum_c;
  logic fits;
  res_t fin_next, fin, out_q, skid;
  logic fin_valid, out_valid, skid_valid;

  assign en = !skid_valid;
  assign req.ready = en;

  always_comb begin
    nodes[0] = req.node_0;
    nodes[1] = req.node_1;
    nodes[2] = req.node_2;
    nodes[3] = req.node_3;
    samples[0] = req.sample_0;
    samples[1] = req.sample_1;
    samples[2] = req.sample_2;
    samples[3] = req.sample_3;
    degen_next = (nodes[0] == nodes[1]) || (nodes[0] == nodes[2]) ||
                 (nodes[0] == nodes[3]) || (nodes[1] == nodes[2]) ||
                 (nodes[1] == nodes[3]) || (nodes[2] == nodes[3]);
    for (int i = 0; i < 4; i++) begin
      lane_next[i].op = req.op;
      lane_next[i].g  = samples[i];
      lane_next[i].a  = DW'(req.point) - DW'(nodes[cli_pkg::other_node(2'(i), 2'd0)]);
      lane_next[i].b  = DW'(req.point) - DW'(nodes[cli_pkg::other_node(2'(i), 2'd1)]);
      lane_next[i].c  = DW'(req.point) - DW'(nodes[cli_pkg::other_node(2'(i), 2'd2)]);
      lane_next[i].p  = DW'(nodes[i]) - DW'(nodes[cli_pkg::other_node(2'(i), 2'd0)]);
      lane_next[i].q  = DW'(nodes[i]) - DW'(nodes[cli_pkg::other_node(2'(i), 2'd1)]);
      lane_next[i].r  = DW'(nodes[i]) - DW'(nodes[cli_pkg::other_node(2'(i), 2'd2)]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        lane_q[i] <= lane_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side0.op    <= req.op;
      side0.degen <= degen_next;
    end
    if (rst) begin
      side0.vld <= 1'b0;
    end else if (en) begin
      side0.vld <= req.valid;
    end
  end

  for (genvar i = 0; i < 4; i++) begin : g_lane
    cli_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
      .clk (clk),
      .en  (en),
      .li  (lane_q[i]),
      .lo  (div_in[i])
    );
    cli_div u_div (
      .clk  (clk),
      .en   (en),
      .di   (div_in[i]),
      .term (term[i])
    );
  end

  // op and flags ride alongside the lanes and dividers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < ML; k++) begin
        side_d[k].vld <= 1'b0;
      end
    end else if (en) begin
      side_d[0] <= side0;
      for (int k = 1; k < ML; k++) begin
        side_d[k] <= side_d[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p01 <= term[0] + term[1];
      p23 <= term[2] + term[3];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side_a.vld <= 1'b0;
    end else if (en) begin
      side_a <= side_d[ML-1];
    end
  end

  always_comb begin
    sum_c = p01 + p23;
    fits  = (sum_c[SW-1:IW-1] == '0) || (sum_c[SW-1:IW-1] == '1);
    fin_next.degenerate = side_a.degen;
    if (side_a.degen || (side_a.op != cli_pkg::OP_VALUE && side_a.op != cli_pkg::OP_SLOPE &&
                         side_a.op != cli_pkg::OP_CURVE)) begin
      fin_next.answer    = '0;
      fin_next.saturated = 1'b0;
    end else if (fits) begin
      fin_next.answer    = sum_c[IW-1:0];
      fin_next.saturated = 1'b0;
    end else begin
      fin_next.answer    = sum_c[SW-1] ? {1'b1, {(IW-1){1'b0}}} : {1'b0, {(IW-1){1'b1}}};
      fin_next.saturated = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid <= 1'b0;
    end else if (en) begin
      fin_valid <= side_a.vld;
      fin       <= fin_next;
    end
  end

  // output register with one skid slot behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (rsp.ready) begin
        out_q      <= skid;
        skid_valid <= 1'b0;
      end
    end else if (fin_valid) begin
      if (out_valid && !rsp.ready) begin
        skid       <= fin;
        skid_valid <= 1'b1;
      end else begin
        out_q     <= fin;
        out_valid <= 1'b1;
      end
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.answer     = out_q.answer;
  assign rsp.saturated  = out_q.saturated;
  assign rsp.degenerate = out_q.degenerate;

`ifndef SYNTH
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid slot full while output register empty");

  a_skid_holds: assert property (@(posedge clk) disable iff (rst)
    skid_valid && !rsp.ready |=> skid_valid && $stable(skid))
    else $error("skid beat lost while output stalled");

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    fin_valid && fin.degenerate |-> fin.answer == '0 && !fin.saturated)
    else $error("coincident nodes gave a nonzero answer");
`endif

endmodule

// File: tb/tb_top.sv
// self-checking testbench for the cubic lagrange interpolator
`timescale 1ns / 1ps

module tb_top;

  localparam int FB = 16;
  localparam int N_RANDOM = 700;
  localparam int LAT = 142;
  localparam longint CYCLE_LIMIT = 400000;

  typedef logic signed [191:0] wide_t;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] point;
    logic signed [31:0] n0, n1, n2, n3;
    logic signed [31:0] s0, s1, s2, s3;
  } query_t;

  typedef struct packed {
    logic signed [31:0] answer;
    logic               saturated;
    logic               degenerate;
  } answer_t;

  typedef struct packed {
    query_t  q;
    logic    known;
    answer_t a;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  always #5 clk = ~clk;

  cli_req_if req ();
  cli_rsp_if rsp ();

  cubic_lagrange_interpolator #(.FRAC_BITS(FB)) uut (
    .clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source)
  );

  answer_t expected_answers[$];
  int      errors = 0;
  int      results_seen = 0;
  int      sat_seen = 0;
  int      degen_seen = 0;
  longint  cycles = 0;
  bit      stim_done = 1'b0;
  bit      long_hold = 1'b0;

  // lagrange evaluation at x with per-term truncating division, derivative order set by op
  function automatic answer_t interpolate(query_t q);
    answer_t r;
    wide_t y[4];
    wide_t g[4];
    wide_t x, sum, den, num, d0, d1, d2, t;
    wide_t d[3];
    int m;
    r = '0;
    x = q.point;
    y[0] = q.n0; y[1] = q.n1; y[2] = q.n2; y[3] = q.n3;
    g[0] = q.s0; g[1] = q.s1; g[2] = q.s2; g[3] = q.s3;
    for (int i = 0; i < 4; i++)
      for (int j = i + 1; j < 4; j++)
        if (y[i] == y[j]) r.degenerate = 1'b1;
    if (r.degenerate || q.op == cli_pkg::OP_SPARE) return r;
    sum = '0;
    for (int i = 0; i < 4; i++) begin
      den = 1;
      m = 0;
      for (int j = 0; j < 4; j++) begin
        if (j == i) continue;
        den = den * (y[i] - y[j]);
        d[m] = x - y[j];
        m++;
      end
      d0 = d[0]; d1 = d[1]; d2 = d[2];
      case (q.op)
        cli_pkg::OP_VALUE: num = d0 * d1 * d2;
        cli_pkg::OP_SLOPE: num = (d0 * d1 + d0 * d2 + d1 * d2) <<< FB;
        default:           num = (d0 + d1 + d2) <<< (1 + 2 * FB);
      endcase
      t = g[i] * num;
      sum = sum + t / den;  // signed divide truncates toward zero
    end
    if (sum > 192'sh7FFFFFFF) begin
      r.saturated = 1'b1;
      r.answer = 32'h7FFFFFFF;
    end else if (sum < -192'sh80000000) begin
      r.saturated = 1'b1;
      r.answer = 32'h80000000;
    end else begin
      r.answer = sum[31:0];
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
      default: return $signed($urandom_range(0, 16 << FB)) - (8 << FB);
    endcase
  endfunction

  function automatic query_t rand_query();
    query_t q;
    q.op = ($urandom_range(0, 19) == 0) ? cli_pkg::OP_SPARE : 2'($urandom_range(0, 2));
    q.point = rand_coord();
    if ($urandom_range(0, 3) == 0) begin
      q.n0 = rand_coord(); q.n1 = rand_coord(); q.n2 = rand_coord(); q.n3 = rand_coord();
    end else begin
      // well spread ascending nodes near the point
      q.n0 = q.point - ($urandom_range(1, 4 << FB));
      q.n1 = q.n0 + $urandom_range(1, 4 << FB);
      q.n2 = q.n1 + $urandom_range(1, 4 << FB);
      q.n3 = q.n2 + $urandom_range(1, 4 << FB);
    end
    if ($urandom_range(0, 12) == 0) q.n2 = q.n0;
    q.s0 = rand_coord(); q.s1 = rand_coord(); q.s2 = rand_coord(); q.s3 = rand_coord();
    if ($urandom_range(0, 7) == 0) q.s1 = $urandom;
    return q;
  endfunction

  // valid stays high across back to back beats; it drops only for an idle gap
  task automatic send_query(query_t q);
    int gap;
    gap = $urandom_range(0, 5);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.op <= q.op; req.point <= q.point;
    req.node_0 <= q.n0; req.node_1 <= q.n1; req.node_2 <= q.n2; req.node_3 <= q.n3;
    req.sample_0 <= q.s0; req.sample_1 <= q.s1; req.sample_2 <= q.s2; req.sample_3 <= q.s3;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
  endtask

  function automatic row_t row(query_t q, logic known, answer_t a);
    row_t r;
    r.q = q; r.known = known; r.a = a;
    return r;
  endfunction

  function automatic query_t mkq(logic [1:0] op, logic [31:0] x, logic [31:0] n0,
                                 logic [31:0] n1, logic [31:0] n2, logic [31:0] n3,
                                 logic [31:0] s0, logic [31:0] s1, logic [31:0] s2,
                                 logic [31:0] s3);
    query_t q;
    q.op = op; q.point = x; q.n0 = n0; q.n1 = n1; q.n2 = n2; q.n3 = n3;
    q.s0 = s0; q.s1 = s1; q.s2 = s2; q.s3 = s3;
    return q;
  endfunction

  localparam logic [31:0] ONE = 32'h00010000;
  localparam logic [31:0] MAXV = 32'h7FFFFFFF;
  localparam logic [31:0] MINV = 32'h80000000;

  row_t directed[$];

  initial begin
    answer_t none;
    answer_t chk;
    none = '0;
    req.valid = 1'b0; req.op = cli_pkg::OP_VALUE; req.point = '0;
    req.node_0 = '0; req.node_1 = '0; req.node_2 = '0; req.node_3 = '0;
    req.sample_0 = '0; req.sample_1 = '0; req.sample_2 = '0; req.sample_3 = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // coincident nodes give zero with the degenerate flag
    directed.push_back(row(mkq(cli_pkg::OP_VALUE, ONE, 0, 0, ONE, 2 * ONE,
                               MAXV, MAXV, MAXV, MAXV), 1, '{32'd0, 1'b0, 1'b1}));
    directed.push_back(row(mkq(cli_pkg::OP_CURVE, MINV, MAXV, MINV, 5, MAXV, 1, 2, 3, 4),
                           1, '{32'd0, 1'b0, 1'b1}));
    // unused op code
    directed.push_back(row(mkq(cli_pkg::OP_SPARE, ONE, 0, ONE, 2 * ONE, 3 * ONE,
                               ONE, ONE, ONE, ONE), 1, '{32'd0, 1'b0, 1'b0}));
    directed.push_back(row(mkq(cli_pkg::OP_SPARE, ONE, 0, 0, 2 * ONE, 3 * ONE,
                               ONE, ONE, ONE, ONE), 1, '{32'd0, 1'b0, 1'b1}));
    // constant function: value equals the constant, derivatives near zero
    directed.push_back(row(mkq(cli_pkg::OP_VALUE, ONE / 2, 0, ONE, 2 * ONE, 3 * ONE,
                               5 * ONE, 5 * ONE, 5 * ONE, 5 * ONE), 1, '{5 * ONE, 1'b0, 1'b0}));
    // per-term truncation leaves a small residue on the slope
    directed.push_back(row(mkq(cli_pkg::OP_SLOPE, ONE / 2, 0, ONE, 2 * ONE, 3 * ONE,
                               5 * ONE, 5 * ONE, 5 * ONE, 5 * ONE), 0, none));
    directed.push_back(row(mkq(cli_pkg::OP_CURVE, ONE / 2, 0, ONE, 2 * ONE, 3 * ONE,
                               5 * ONE, 5 * ONE, 5 * ONE, 5 * ONE), 1, none));
    // evaluation at a node returns its sample
    directed.push_back(row(mkq(cli_pkg::OP_VALUE, ONE, 0, ONE, 2 * ONE, 3 * ONE,
                               7, MINV, 9, 11), 1, '{MINV, 1'b0, 1'b0}));
    // saturation both ways: huge samples, close nodes, far point; then further slope and curvature cases
    directed.push_back(row(mkq(cli_pkg::OP_VALUE, MAXV, MINV, MINV + 1, MINV + 2, MINV + 3,
                               MAXV, MINV, MAXV, MINV), 0, none));
    directed.push_back(row(mkq(cli_pkg::OP_VALUE, MAXV, MINV, MINV + 1, MINV + 2, MINV + 3,
                               MINV, MAXV, MINV, MAXV), 0, none));
    directed.push_back(row(mkq(cli_pkg::OP_SLOPE, MINV, MAXV, MAXV - 1, MAXV - 2, MAXV - 3,
                               MAXV, MAXV, MINV, MINV), 0, none));
    directed.push_back(row(mkq(cli_pkg::OP_CURVE, 0, MINV, MAXV, 0, 1,
                               MAXV, MINV, MAXV, MINV), 0, none));
    directed.push_back(row(mkq(cli_pkg::OP_SLOPE, 3 * ONE / 2, 0, ONE, 2 * ONE, 3 * ONE,
                               0, ONE, 4 * ONE, 9 * ONE), 0, none));
    directed.push_back(row(mkq(cli_pkg::OP_CURVE, MAXV, MAXV, MINV, -1, 1,
                               32'hFFFFFFFF, 32'h55555555, 32'hAAAAAAAA, 0), 0, none));

    foreach (directed[i]) begin
      chk = interpolate(directed[i].q);
      expected_answers.push_back(directed[i].known ? directed[i].a : chk);
      send_query(directed[i].q);
    end
    for (int i = 0; i < N_RANDOM; i++) begin
      query_t q;
      q = rand_query();
      expected_answers.push_back(interpolate(q));
      if (i == N_RANDOM / 3) long_hold = 1'b1;
      send_query(q);
    end
    req.valid <= 1'b0;
    stim_done = 1'b1;
  end

  // result side: random stalls plus one long hold-off to back the pipeline up
  initial begin
    int stall;
    rsp.ready = 1'b0;
    @(negedge rst);
    forever begin
      if (long_hold) begin
        rsp.ready <= 1'b0;
        long_hold = 1'b0;
        repeat (400) @(posedge clk);
      end
      stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        rsp.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp.ready <= 1'b1;
      @(posedge clk);
      while (!rsp.valid) @(posedge clk);
      // the beat moves at this edge; check it here
      if (expected_answers.size() == 0) begin
        report_mismatch("unexpected beat", rsp.answer, 0);
      end else begin
        answer_t e;
        e = expected_answers.pop_front();
        if (rsp.answer !== e.answer) report_mismatch("answer", rsp.answer, e.answer);
        if (rsp.saturated !== e.saturated)
          report_mismatch("saturated", rsp.saturated, e.saturated);
        if (rsp.degenerate !== e.degenerate)
          report_mismatch("degenerate", rsp.degenerate, e.degenerate);
        results_seen++;
        sat_seen += rsp.saturated;
        degen_seen += rsp.degenerate;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("cubic_lagrange_interpolator regression: fail");
      $finish;
    end
  end

  initial begin
    wait (stim_done);
    while (expected_answers.size() != 0) @(posedge clk);
    repeat (LAT + 20) @(posedge clk);
    $display("checked %0d results, %0d saturated, %0d with coincident nodes",
             results_seen, sat_seen, degen_seen);
    $display("covered value, slope, curvature and unused op with random stalls");
    if (errors == 0) begin
      $display("cubic_lagrange_interpolator regression: pass");
    end else begin
      $display("cubic_lagrange_interpolator regression: fail");
    end
    $finish;
  end

endmodule
